// ===== src/ssort_pkg.sv =====
package ssort_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 10;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    WR_IN,
    WR_POSVAL,
    WR_MIN
  } wr_src_t;

  typedef struct packed {
    logic             wr_en;
    wr_src_t          wr_src;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_first;
    logic             rd_emit;
    logic             emit_last;
    logic             emit_ovf;
  } cmd_t;

endpackage

// ===== src/ssort_ram.sv =====
module ssort_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ssort_datapath.sv =====
module ssort_datapath
  import ssort_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_strobe,
  output logic [VAL_W-1:0] out_sorted_value,
  output logic             out_last_res,
  output logic             out_overflow
);

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [VAL_W-1:0] wdata;
  logic [VAL_W-1:0] rdata;

  logic             cmp_vld_r;
  logic             cmp_first_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             emit_vld_r;
  logic             emit_last_r;
  logic             emit_ovf_r;

  logic [VAL_W-1:0] min_r;
  logic [VAL_W-1:0] posval_r;
  logic [IDX_W-1:0] best_r;

  logic             strobe_r;
  logic [VAL_W-1:0] sorted_r;
  logic             last_r;
  logic             ovf_r;

  always_comb begin
    we    = cmd.wr_en;
    waddr = cmd.wr_addr;
    wdata = in_value;
    case (cmd.wr_src)
      WR_IN: begin
        waddr = cmd.wr_addr;
        wdata = in_value;
      end
      WR_POSVAL: begin
        waddr = best_r;
        wdata = posval_r;
      end
      WR_MIN: begin
        waddr = cmd.wr_addr;
        wdata = min_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ssort_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r  <= 1'b0;
      emit_vld_r <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      cmp_vld_r  <= cmd.rd_en & ~cmd.rd_emit;
      emit_vld_r <= cmd.rd_en & cmd.rd_emit;
      strobe_r   <= emit_vld_r;
    end
    cmp_first_r <= cmd.rd_first;
    cmp_idx_r   <= cmd.rd_addr;
    emit_last_r <= cmd.emit_last;
    emit_ovf_r  <= cmd.emit_ovf;
    if (cmp_vld_r) begin
      if (cmp_first_r) begin
        min_r    <= rdata;
        posval_r <= rdata;
        best_r   <= cmp_idx_r;
      end else if (rdata < min_r) begin
        min_r  <= rdata;
        best_r <= cmp_idx_r;
      end
    end
    if (emit_vld_r) begin
      sorted_r <= rdata;
      last_r   <= emit_last_r;
      ovf_r    <= emit_ovf_r;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_sorted_value = sorted_r;
  assign out_last_res     = last_r;
  assign out_overflow     = ovf_r;

endmodule

// ===== src/ssort_ctrl.sv =====
module ssort_ctrl
  import ssort_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic in_last,
  output logic busy,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             ovf_r, ovf_nxt;

  logic             has_room;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W:0]   pos_plus2;
  logic [CNT_W-1:0] count_m1;

  assign has_room  = (count_r < CNT_W'(DEPTH));
  assign count_inc = count_r + CNT_W'(1);
  assign pos_plus2 = {1'b0, pos_r} + (CNT_W + 1)'(2);
  assign count_m1  = count_r - CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    scan_nxt  = scan_r;
    ovf_nxt   = ovf_r;

    cmd           = '0;
    cmd.wr_src    = WR_IN;
    cmd.rd_addr   = scan_r[IDX_W-1:0];
    cmd.wr_addr   = pos_r[IDX_W-1:0];
    cmd.emit_ovf  = ovf_r;
    cmd.emit_last = (scan_r == count_m1);

    unique case (state_r)
      ST_IDLE: begin
        cmd.wr_addr = count_r[IDX_W-1:0];
        if (start) begin
          if (has_room) begin
            cmd.wr_en = 1'b1;
            count_nxt = count_inc;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            pos_nxt  = '0;
            scan_nxt = '0;
            if (has_room ? (count_inc > CNT_W'(1)) : (count_r > CNT_W'(1))) begin
              state_nxt = ST_SCAN;
            end else begin
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (scan_r == pos_r);
        if (scan_r == count_m1) begin
          state_nxt = ST_WAIT;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      ST_WAIT: begin
        state_nxt = ST_SWAP_A;
      end
      ST_SWAP_A: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_POSVAL;
        state_nxt  = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_MIN;
        pos_nxt    = pos_r + CNT_W'(1);
        if (pos_plus2 < {1'b0, count_r}) begin
          scan_nxt  = pos_r + CNT_W'(1);
          state_nxt = ST_SCAN;
        end else begin
          scan_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_emit = 1'b1;
        if (scan_r == count_m1) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      pos_r   <= '0;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      pos_r   <= pos_nxt;
      scan_r  <= scan_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== src/selection_sort_engine_unit.sv =====
// Channel   Ports                                              Handshake
// input     in_value, in_last                                  start high, busy low
// result    out_sorted_value, out_last_res, out_overflow       out_strobe, one cycle
//
// Loading writes each accepted word into the store. Closing a set of n words starts
// the sort: each pass p scans n-p entries through the single read port of the store,
// one per cycle, then uses ST_WAIT for compare drain and ST_SWAP_A/ST_SWAP_B for the
// two-write swap. Emission reads one entry per cycle; the first result appears after
// the store's read register and the output register. Reset clears the controller
// and the result strobe; the receiver cannot stall, so results are never held back.
module selection_sort_engine_unit
  import ssort_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [VAL_W-1:0] in_value,
  input  logic             in_last,
  output logic             out_strobe,
  output logic [VAL_W-1:0] out_sorted_value,
  output logic             out_last_res,
  output logic             out_overflow
);

  cmd_t cmd;

  ssort_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .busy    (busy),
    .cmd     (cmd)
  );

  ssort_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_last_res     (out_last_res),
    .out_overflow     (out_overflow)
  );

endmodule
